// ----- rtl/configurable_crc16_generate_check_top_macros.svh -----
// Assertion macros for the configurable CRC-16 generator and checker.
`ifndef CONFIGURABLE_CRC16_GENERATE_CHECK_TOP_MACROS_SVH
`define CONFIGURABLE_CRC16_GENERATE_CHECK_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, off while reset is high.
`define CCRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CCRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CCRC_ASSERT(lbl, clk, rst, prop, msg)
`define CCRC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/ccrc16_pkg.sv -----
// Types, register map and CRC helper functions for the CRC-16 block.
`timescale 1ns / 1ps
`default_nettype none

package ccrc16_pkg;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_POLY       = 3'd0;
   localparam logic [2:0] REG_START      = 3'd1;
   localparam logic [2:0] REG_FINAL_XOR  = 3'd2;
   localparam logic [2:0] REG_REFLECT_IN = 3'd3;
   localparam logic [2:0] REG_REFLECT_OUT = 3'd4;
   localparam logic [2:0] REG_HIGH_FIRST = 3'd5;

   localparam logic [15:0] POLY_RESET      = 16'h8005;
   localparam logic [15:0] START_RESET     = 16'hFFFF;
   localparam logic [15:0] FINAL_XOR_RESET = 16'h0000;
   localparam logic        REFLECT_IN_RESET  = 1'b1;
   localparam logic        REFLECT_OUT_RESET = 1'b1;
   localparam logic        HIGH_FIRST_RESET  = 1'b0;

   localparam logic [1:0] COUNT_MAX = 2'd3;

   typedef struct packed {
      logic [15:0] poly_value;
      logic [15:0] start_value;
      logic [15:0] final_xor;
      logic        reflect_in;
      logic        reflect_out;
      logic        high_byte_first;
   } cfg_type;

   typedef struct packed {
      logic        too_short;
      logic        check_ok;
      logic [7:0]  wire_second;
      logic [7:0]  wire_first;
      logic [15:0] crc_value;
   } result_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   function automatic logic [15:0] rev16(input logic [15:0] v);
      logic [15:0] r;
      for (int i = 0; i < 16; i++) begin
         r[i] = v[15-i];
      end
      return r;
   endfunction

   // one byte through the bitwise CRC, MSB-first register
   function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                            input logic [7:0]  data_in,
                                            input logic [15:0] poly,
                                            input logic        refl);
      logic [15:0] c;
      logic [7:0]  d;
      d = refl ? rev8(data_in) : data_in;
      c = crc ^ {d, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ poly) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [15:0] crc_finish(input logic [15:0] crc,
                                              input logic        refl,
                                              input logic [15:0] fxor);
      return (refl ? rev16(crc) : crc) ^ fxor;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/configurable_crc16_generate_check_top.sv -----
// Top level: configurable CRC-16 generator/checker with APB registers and stream ports.
//
// Takes one message byte per cycle on the req_ stream while req_tready is high and
// gives one result item on rsp_ for every byte marked tlast. The whole CRC update
// (eight polynomial steps of the bitwise model, input/output reflection and final XOR)
// is combinational between the message state and the result register. A two-entry
// result buffer keeps req_tready high while one result waits; req_tready falls only
// when both entries are full. Generate mode feeds every byte; verify mode keeps the
// last two bytes as the received check and compares them in the byte order set by
// high_byte_first. Registers are at byte addresses 0x00 (poly), 0x04 (start), 0x08
// (final XOR), 0x0C (reflect in), 0x10 (reflect out) and 0x14 (high byte first);
// write them only while no message is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "configurable_crc16_generate_check_top_macros.svh"

module configurable_crc16_generate_check_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [7:0]                          req_tdata,  // [7:0] data_byte
   input  wire logic                                req_tuser,  // [0] action
   input  wire logic                                req_tlast,  // last_byte
   // result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [31:0]                              rsp_tdata,  // [15:0] crc_value,
                                                                // [23:16] wire_first,
                                                                // [31:24] wire_second
   output logic [1:0]                               rsp_tuser,  // [0] check_ok,
                                                                // [1] too_short
   // register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [ccrc16_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [ccrc16_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ccrc16_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                     csr_pready
);
   import ccrc16_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   result_type result;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic       req_accept;
   logic       push;
   logic       pop;
   logic       csr_write;
   logic [2:0] csr_index;

   // ---------------- registers ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_POLY:        cfg_in.poly_value      = csr_pwdata[15:0];
            REG_START:       cfg_in.start_value     = csr_pwdata[15:0];
            REG_FINAL_XOR:   cfg_in.final_xor       = csr_pwdata[15:0];
            REG_REFLECT_IN:  cfg_in.reflect_in      = csr_pwdata[0];
            REG_REFLECT_OUT: cfg_in.reflect_out     = csr_pwdata[0];
            REG_HIGH_FIRST:  cfg_in.high_byte_first = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_POLY:        csr_prdata = {16'h0000, cfg_ff.poly_value};
         REG_START:       csr_prdata = {16'h0000, cfg_ff.start_value};
         REG_FINAL_XOR:   csr_prdata = {16'h0000, cfg_ff.final_xor};
         REG_REFLECT_IN:  csr_prdata = {31'd0, cfg_ff.reflect_in};
         REG_REFLECT_OUT: csr_prdata = {31'd0, cfg_ff.reflect_out};
         REG_HIGH_FIRST:  csr_prdata = {31'd0, cfg_ff.high_byte_first};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poly_value      <= POLY_RESET;
         cfg_ff.start_value     <= START_RESET;
         cfg_ff.final_xor       <= FINAL_XOR_RESET;
         cfg_ff.reflect_in      <= REFLECT_IN_RESET;
         cfg_ff.reflect_out     <= REFLECT_OUT_RESET;
         cfg_ff.high_byte_first <= HIGH_FIRST_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- CRC engine ----------------
   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   ccrc16_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step_en   (req_accept),
      .action    (req_tuser),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .result    (result)
   );

   // ---------------- result buffer ----------------
   assign push = req_accept && req_tlast;
   assign pop  = out_valid_ff && rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            // skid full means no push this cycle
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = push;
            out_data_in   = result;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_data_ff.wire_second, out_data_ff.wire_first,
                        out_data_ff.crc_value};
   assign rsp_tuser  = {out_data_ff.too_short, out_data_ff.check_ok};

   // ---------------- checks ----------------
   `CCRC_ASSERT(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff, "skid entry without output entry")
   `CCRC_ASSERT(a_last_gives_result, clock, reset, (push && !pop) |=> rsp_tvalid, "last item lost its result")
   `CCRC_ASSERT(a_ok_not_short, clock, reset, rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]), "check_ok with too_short")

endmodule

`default_nettype wire

// ----- rtl/ccrc16_engine.sv -----
// Per-message CRC state, held check bytes and the result of a last item.
`timescale 1ns / 1ps
`default_nettype none

module ccrc16_engine (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ccrc16_pkg::cfg_type     cfg,
   input  wire logic                    step_en,
   input  wire logic                    action,
   input  wire logic [7:0]              data_byte,
   input  wire logic                    last_byte,
   output ccrc16_pkg::result_type       result
);
   import ccrc16_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [1:0]  count_ff, count_in;

   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic [15:0] crc_out;
   logic [15:0] received;
   logic        do_feed;
   logic        short_msg;
   logic [7:0]  feed_data;

   always_comb begin
      crc_base  = (count_ff == 2'd0) ? cfg.start_value : crc_ff;
      // verify bytes lag by two: only the oldest held byte enters the CRC
      do_feed   = !action || (count_ff >= 2'd2);
      feed_data = action ? held0_ff : data_byte;
      crc_next  = do_feed ? crc_feed(crc_base, feed_data, cfg.poly_value, cfg.reflect_in)
                          : crc_base;
      crc_out   = crc_finish(crc_next, cfg.reflect_out, cfg.final_xor);
      received  = cfg.high_byte_first ? {held1_ff, data_byte} : {data_byte, held1_ff};
      short_msg = action && (count_ff <= 2'd1);

      result.crc_value   = crc_out;
      result.wire_first  = cfg.high_byte_first ? crc_out[15:8] : crc_out[7:0];
      result.wire_second = cfg.high_byte_first ? crc_out[7:0] : crc_out[15:8];
      result.too_short   = short_msg;
      result.check_ok    = action && !short_msg && (received == crc_out);
   end

   always_comb begin
      crc_in   = crc_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      count_in = count_ff;
      if (step_en) begin
         if (last_byte) begin
            crc_in   = cfg.start_value;
            held0_in = 8'h00;
            held1_in = 8'h00;
            count_in = 2'd0;
         end else begin
            crc_in   = crc_next;
            held0_in = held1_ff;
            held1_in = data_byte;
            count_in = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= START_RESET;
         held0_ff <= 8'h00;
         held1_ff <= 8'h00;
         count_ff <= 2'd0;
      end else begin
         crc_ff   <= crc_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire
